// File: rtl/p2n_pkg.sv
package p2n_pkg;

  localparam int PITCH_FRAC_BITS = 8;
  localparam int REF_FRAC_BITS   = 8;
  localparam int PITCH_W         = 20;
  localparam int REF_W           = 18;
  localparam int LOG_FRAC        = 16;
  localparam int LOG_STAGES      = LOG_FRAC + 1;

  localparam logic [31:0] MIN_PITCH = 32'(20 << PITCH_FRAC_BITS);

  typedef enum logic [1:0] {
    CFG_REF_PITCH = 2'd0,
    CFG_MODE      = 2'd1,
    CFG_ENABLE    = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  localparam logic [5:0]  STEP_N [8] = '{6'd12, 6'd19, 6'd24, 6'd31, 6'd41, 6'd53, 6'd12, 6'd12};
  localparam logic [3:0]  OCT_ADJ [8] = '{4'd3, 4'd6, 4'd7, 4'd9, 4'd11, 4'd15, 4'd3, 4'd3};
  // floor(2^20 / n) + 1
  localparam logic [16:0] RECIP_N [8] = '{17'd87382, 17'd55189, 17'd43691, 17'd33826,
                                          17'd25576, 17'd19785, 17'd87382, 17'd87382};
  // floor(2^20 / (2n)) + 1
  localparam logic [15:0] RECIP_2N [8] = '{16'd43691, 16'd27595, 16'd21846, 16'd16913,
                                           16'd12788, 16'd9893, 16'd43691, 16'd43691};

  typedef struct packed {
    logic [REF_W-1:0] ref_pitch;
    logic [2:0]       mode;
    logic             enable;
  } cfg_t;

  typedef struct packed {
    logic                act;
    logic [4:0]          msb_p;
    logic [4:0]          msb_r;
    logic [LOG_FRAC-1:0] frac_p;
    logic [LOG_FRAC-1:0] frac_r;
  } log_res_t;

endpackage

// File: rtl/pitch_to_note_quantizer.sv
// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_ready_o   | pitch_in_i
// out     | output    | out_valid_o / out_ready_i | active_o .. sharp_mark_o
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat enters per cycle while in_ready_o is high. Each beat passes through the
// normalize stage and the 16 squaring stages of the log2 pipeline, then the
// four rounding stages. Each stage holds on a stall and refills bubbles.
// Reset clears the valid bits and loads the register defaults; cfg_ready_o is
// always high.
module pitch_to_note_quantizer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [p2n_pkg::PITCH_W-1:0]  pitch_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         active_o,
  output logic [5:0]                   note_index_o,
  output logic [2:0]                   octave_index_o,
  output logic signed [13:0]           cent_offset_o,
  output logic                         in_tune_o,
  output logic                         flat_mark_o,
  output logic                         sharp_mark_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [p2n_pkg::REF_W-1:0]    cfg_data_i
);

  p2n_pkg::cfg_t     cfg_q;
  p2n_pkg::log_res_t lres;
  logic              l_valid, l_ready;
  logic              act_in;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_pitch <= 18'd112640;
      cfg_q.mode      <= 3'd0;
      cfg_q.enable    <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (p2n_pkg::cfg_idx_e'(cfg_index_i))
        p2n_pkg::CFG_REF_PITCH: cfg_q.ref_pitch <= cfg_data_i;
        p2n_pkg::CFG_MODE:      cfg_q.mode      <= cfg_data_i[2:0];
        p2n_pkg::CFG_ENABLE:    cfg_q.enable    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign act_in = cfg_q.enable & (32'(pitch_in_i) >= p2n_pkg::MIN_PITCH);

  p2n_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .act_i   (act_in),
    .pitch_i (pitch_in_i),
    .ref_i   (cfg_q.ref_pitch),
    .valid_o (l_valid),
    .ready_i (l_ready),
    .res_o   (lres)
  );

  p2n_round u_round (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (l_valid),
    .ready_o        (l_ready),
    .res_i          (lres),
    .mode_i         (cfg_q.mode),
    .valid_o        (out_valid_o),
    .ready_i        (out_ready_i),
    .active_o       (active_o),
    .note_index_o   (note_index_o),
    .octave_index_o (octave_index_o),
    .cent_offset_o  (cent_offset_o),
    .in_tune_o      (in_tune_o),
    .flat_mark_o    (flat_mark_o),
    .sharp_mark_o   (sharp_mark_o)
  );

endmodule

// File: rtl/p2n_log2.sv
module p2n_log2 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic                          act_i,
  input  logic [p2n_pkg::PITCH_W-1:0]   pitch_i,
  input  logic [p2n_pkg::REF_W-1:0]     ref_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output p2n_pkg::log_res_t             res_o
);

  localparam int NS = p2n_pkg::LOG_STAGES;
  localparam int FW = p2n_pkg::LOG_FRAC;

  function automatic logic [35:0] normalize(logic [p2n_pkg::PITCH_W-1:0] x);
    logic [4:0]  msb;
    logic [30:0] xe;
    msb = '0;
    for (int i = 0; i < p2n_pkg::PITCH_W; i++) begin
      if (x[i]) msb = 5'(i);
    end
    xe = 31'(x);
    return {msb, 31'(xe << (5'd30 - msb))};
  endfunction

  function automatic logic [31:0] sq_step(logic [30:0] m);
    logic [61:0] p;
    logic [31:0] s;
    p = 62'(m) * 62'(m);
    s = p[61:30];
    return {s[31], (s[31] ? s[31:1] : s[30:0])};
  endfunction

  function automatic logic [p2n_pkg::PITCH_W-1:0] PITCH_W_EXT(logic [p2n_pkg::REF_W-1:0] r);
    return p2n_pkg::PITCH_W'((r == '0) ? p2n_pkg::REF_W'(1) : r);
  endfunction

  logic              vld_q  [NS];
  logic              act_q  [NS];
  logic [4:0]        msbp_q [NS];
  logic [4:0]        msbr_q [NS];
  logic [30:0]       mp_q   [NS];
  logic [30:0]       mr_q   [NS];
  logic [FW-1:0]     fp_q   [NS];
  logic [FW-1:0]     fr_q   [NS];
  logic [NS:0]       rdy;
  logic [31:0]       sp_d   [NS];
  logic [31:0]       sr_d   [NS];
  logic [35:0]       np_d;
  logic [35:0]       nr_d;

  always_comb begin
    rdy[NS] = ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = ~vld_q[k] | rdy[k+1];
    end
  end

  always_comb begin
    np_d = normalize(pitch_i);
    nr_d = normalize(PITCH_W_EXT(ref_i));
    sp_d[0] = '0;
    sr_d[0] = '0;
    for (int k = 1; k < NS; k++) begin
      sp_d[k] = sq_step(mp_q[k-1]);
      sr_d[k] = sq_step(mr_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) vld_q[k] <= 1'b0;
    end else begin
      if (rdy[0]) vld_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      act_q[0]  <= act_i;
      msbp_q[0] <= np_d[35:31];
      mp_q[0]   <= np_d[30:0];
      msbr_q[0] <= nr_d[35:31];
      mr_q[0]   <= nr_d[30:0];
      fp_q[0]   <= '0;
      fr_q[0]   <= '0;
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        act_q[k]  <= act_q[k-1];
        msbp_q[k] <= msbp_q[k-1];
        msbr_q[k] <= msbr_q[k-1];
        mp_q[k]   <= sp_d[k][30:0];
        mr_q[k]   <= sr_d[k][30:0];
        fp_q[k]   <= {fp_q[k-1][FW-2:0], sp_d[k][31]};
        fr_q[k]   <= {fr_q[k-1][FW-2:0], sr_d[k][31]};
      end
    end
  end

  assign ready_o      = rdy[0];
  assign valid_o      = vld_q[NS-1];
  assign res_o.act    = act_q[NS-1];
  assign res_o.msb_p  = msbp_q[NS-1];
  assign res_o.msb_r  = msbr_q[NS-1];
  assign res_o.frac_p = fp_q[NS-1];
  assign res_o.frac_r = fr_q[NS-1];

endmodule

// File: rtl/p2n_round.sv
module p2n_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  p2n_pkg::log_res_t    res_i,
  input  logic [2:0]           mode_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic                 active_o,
  output logic [5:0]           note_index_o,
  output logic [2:0]           octave_index_o,
  output logic signed [13:0]   cent_offset_o,
  output logic                 in_tune_o,
  output logic                 flat_mark_o,
  output logic                 sharp_mark_o
);

  logic [5:0]  n;
  logic [3:0]  adj;
  logic [16:0] rcp_n;
  logic [15:0] rcp_2n;

  assign n      = p2n_pkg::STEP_N[mode_i];
  assign adj    = p2n_pkg::OCT_ADJ[mode_i];
  assign rcp_n  = p2n_pkg::RECIP_N[mode_i];
  assign rcp_2n = p2n_pkg::RECIP_2N[mode_i];

  logic va_q, vb_q, vc_q, vd_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  assign rdy_d   = ~vd_q | ready_i;
  assign rdy_c   = ~vc_q | rdy_d;
  assign rdy_b   = ~vb_q | rdy_c;
  assign rdy_a   = ~va_q | rdy_b;
  assign ready_o = rdy_a;
  assign valid_o = vd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
    end
  end

  // stage a: log ratio and scaled step position
  logic signed [23:0] lhi, l, t;
  logic signed [30:0] fvis_d, fvis_q;
  logic               act_a_q;

  always_comb begin
    lhi = 24'($signed({1'b0, res_i.msb_p})) - 24'($signed({1'b0, res_i.msb_r}))
          + 24'(p2n_pkg::REF_FRAC_BITS - p2n_pkg::PITCH_FRAC_BITS);
    l   = (lhi <<< p2n_pkg::LOG_FRAC) + $signed({8'b0, res_i.frac_p})
          - $signed({8'b0, res_i.frac_r});
    t   = l + 24'sd262144;
    fvis_d = 31'($signed({1'b0, n})) * 31'(t);
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      fvis_q  <= fvis_d;
      act_a_q <= res_i.act;
    end
  end

  // stage b: round to nearest step
  logic        fneg;
  logic [30:0] fmag, vsum;
  logic [12:0] vm;
  logic signed [12:0] v_d, v_q;
  logic signed [30:0] fr_full;
  logic signed [16:0] frac_q;
  logic               act_b_q;

  always_comb begin
    fneg    = fvis_q[30];
    fmag    = fneg ? 31'(-fvis_q) : 31'(fvis_q);
    vsum    = fmag + 31'd32768;
    vm      = vsum[28:16];
    v_d     = fneg ? -$signed(vm) : $signed(vm);
    fr_full = fvis_q - (31'(v_d) <<< p2n_pkg::LOG_FRAC);
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b) begin
      v_q     <= v_d;
      frac_q  <= fr_full[16:0];
      act_b_q <= act_a_q;
    end
  end

  // stage c: reciprocal products
  logic signed [12:0] x;
  logic        xneg;
  logic [12:0] ax, y;
  logic [10:0] vp_d, vp_q;
  logic [15:0] a;
  logic [28:0] po_q;
  logic [27:0] pn_q;
  logic [29:0] pc_q;
  logic [25:0] pt_q;
  logic        xneg_q, sneg_q, act_c_q;

  always_comb begin
    x    = v_q + $signed({9'b0, adj});
    xneg = x[12];
    ax   = xneg ? 13'(-x) : 13'(x);
    y    = {ax[11:0], 1'b0} + 13'(n);
    vp_d = 11'(v_q + $signed({5'b0, n, 2'b00}));
    a    = frac_q[16] ? 16'(-frac_q) : 16'(frac_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c) begin
      po_q    <= 29'(y) * 29'(rcp_2n);
      pn_q    <= 28'(vp_d) * 28'(rcp_n);
      pc_q    <= 30'(a) * 30'(14'd10000);
      pt_q    <= 26'(a) * 26'(10'd1000);
      vp_q    <= vp_d;
      xneg_q  <= xneg;
      sneg_q  <= frac_q[16];
      act_c_q <= act_b_q;
    end
  end

  // stage d: octave, note, deviation and marks
  logic [8:0]  qo;
  logic [7:0]  qn;
  logic [2:0]  oct_d;
  logic [10:0] note_full;
  logic [29:0] csum;
  logic [13:0] cmag;
  logic        big;

  always_comb begin
    qo = po_q[28:20];
    qn = pn_q[27:20];
    if (xneg_q) begin
      oct_d = (qo == '0) ? 3'd0 : 3'd6;
    end else begin
      oct_d = (qo > 9'd5) ? 3'd6 : qo[2:0];
    end
    note_full = vp_q - 11'(11'(qn) * 11'(n));
    csum      = pc_q + 30'd32768;
    cmag      = csum[29:16];
    big       = pt_q >= 26'd1048576;
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d) begin
      active_o       <= act_c_q;
      note_index_o   <= act_c_q ? note_full[5:0] : 6'd0;
      octave_index_o <= act_c_q ? oct_d : 3'd0;
      cent_offset_o  <= act_c_q ? (sneg_q ? -$signed(cmag) : $signed(cmag)) : 14'sd0;
      in_tune_o      <= act_c_q & (pt_q < 26'd262144);
      flat_mark_o    <= act_c_q & sneg_q & big;
      sharp_mark_o   <= act_c_q & ~sneg_q & big;
    end
  end

endmodule

// File: rtl/p2n_checker.sv
module p2n_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [p2n_pkg::PITCH_W-1:0] pitch_in_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        active_o,
  input logic [5:0]                  note_index_o,
  input logic [2:0]                  octave_index_o,
  input logic signed [13:0]          cent_offset_o,
  input logic                        in_tune_o,
  input logic                        flat_mark_o,
  input logic                        sharp_mark_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(pitch_in_i))
    else $error("input beat changed while stalled");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cent_offset_o)
      && $stable(note_index_o) && $stable(octave_index_o) && $stable(active_o))
    else $error("output beat changed while stalled");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !active_o |-> note_index_o == 6'd0 && octave_index_o == 3'd0
      && cent_offset_o == 14'sd0 && !in_tune_o && !flat_mark_o && !sharp_mark_o)
    else $error("inactive beat carries nonzero fields");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> note_index_o <= 6'd52 && octave_index_o <= 3'd6
      && cent_offset_o >= -14'sd5000 && cent_offset_o <= 14'sd5000)
    else $error("output field out of range");

  a_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({in_tune_o, flat_mark_o, sharp_mark_o}))
    else $error("tuning marks conflict");

endmodule

bind pitch_to_note_quantizer p2n_checker u_p2n_checker (.*);

// File: verif/tb_pitch_to_note_quantizer.sv
module tb_pitch_to_note_quantizer;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SEG_ITEMS   = 200;
  localparam int NUM_SEGS    = 8;
  localparam int DRAIN_WAIT  = 40;
  localparam int HOLD_CYCLES = 300;
  localparam longint Q16 = 65536;

  typedef struct packed {
    logic              act;
    logic [5:0]        note;
    logic [2:0]        oct;
    logic signed [13:0] cent;
    logic              tune;
    logic              flat;
    logic              sharp;
  } note_res_t;

  typedef struct {
    logic [p2n_pkg::PITCH_W-1:0] pitch;
    bit                          typed;
    note_res_t                   res;
  } pitch_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [p2n_pkg::PITCH_W-1:0]  pitch_in_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic                         active_o;
  logic [5:0]                   note_index_o;
  logic [2:0]                   octave_index_o;
  logic signed [13:0]           cent_offset_o;
  logic                         in_tune_o;
  logic                         flat_mark_o;
  logic                         sharp_mark_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [1:0]                   cfg_index_i;
  logic [p2n_pkg::REF_W-1:0]    cfg_data_i;

  pitch_to_note_quantizer uut (.*);

  logic [p2n_pkg::REF_W-1:0] ref_q;
  logic [2:0]                mode_q;
  logic                      enable_q;

  note_res_t notes_pending[$];
  int        err_cnt;
  int        cyc_cnt;
  int        send_idle;
  int        recv_idle;
  bit        hold_req;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint log2_fix(longint unsigned x);
    int              msb;
    longint unsigned m;
    longint          fr;
    msb = 0;
    fr  = 0;
    while (msb < 62 && (x >> (msb + 1)) != 0) msb++;
    m = x << (30 - msb);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      fr = fr << 1;
      if (m >= (64'd1 << 31)) begin
        fr = fr | 1;
        m = m >> 1;
      end
    end
    return longint'(msb) * Q16 + fr;
  endfunction

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (2 * n + d) / (2 * d);
    return -((-2 * n + d) / (2 * d));
  endfunction

  function automatic note_res_t quantize_pitch(logic [p2n_pkg::PITCH_W-1:0] pitch);
    longint    steps [8] = '{12, 19, 24, 31, 41, 53, 12, 12};
    longint    shift [8] = '{3, 6, 7, 9, 11, 15, 3, 3};
    note_res_t r;
    longint    n, l, fvis, v, fr, oct, nt, cent;
    longint unsigned rp;
    r = '0;
    if (!enable_q || pitch < (20 << p2n_pkg::PITCH_FRAC_BITS)) return r;
    rp = (ref_q == 0) ? 1 : ref_q;
    n = steps[mode_q];
    l = log2_fix(pitch) - p2n_pkg::PITCH_FRAC_BITS * Q16 - log2_fix(rp)
        + p2n_pkg::REF_FRAC_BITS * Q16;
    fvis = n * (l + 4 * Q16);
    v = round_div(fvis, Q16);
    fr = fvis - v * Q16;
    oct = round_div(v + shift[mode_q], n);
    if (oct < 0 || oct > 5) oct = 6;
    nt = v % n;
    if (nt < 0) nt += n;
    cent = round_div(fr * 10000, Q16);
    r.act   = 1'b1;
    r.note  = nt[5:0];
    r.oct   = oct[2:0];
    r.cent  = cent[13:0];
    r.tune  = ((fr * 1000) / (4 * Q16) == 0);
    r.flat  = (fr * 1000 <= -1048576);
    r.sharp = (fr * 1000 >= 1048576);
    return r;
  endfunction

  task automatic write_reg(p2n_pkg::cfg_idx_e idx, logic [p2n_pkg::REF_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      p2n_pkg::CFG_REF_PITCH: ref_q = data;
      p2n_pkg::CFG_MODE:      mode_q = data[2:0];
      p2n_pkg::CFG_ENABLE:    enable_q = data[0];
      default: ;
    endcase
  endtask

  task automatic load_tuning(logic [p2n_pkg::REF_W-1:0] rp, logic [2:0] md, logic en);
    write_reg(p2n_pkg::CFG_REF_PITCH, rp);
    write_reg(p2n_pkg::CFG_MODE, p2n_pkg::REF_W'(md));
    write_reg(p2n_pkg::CFG_ENABLE, p2n_pkg::REF_W'(en));
    write_reg(p2n_pkg::CFG_UNUSED, p2n_pkg::REF_W'($urandom));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // returns at the edge that accepts the beat; valid is left as it is
  task automatic offer_pitch(logic [p2n_pkg::PITCH_W-1:0] p, bit typed, note_res_t res);
    in_valid_i <= 1'b1;
    pitch_in_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    notes_pending.push_back(typed ? res : quantize_pitch(p));
  endtask

  task automatic pause_sender(bit last);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle) gap++;
    if (gap > 0 || last) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    while (notes_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [p2n_pkg::PITCH_W-1:0] pick_pitch();
    int k;
    case ($urandom_range(9))
      0, 1:    return p2n_pkg::PITCH_W'($urandom_range(0, 5300));
      2, 3, 4: return p2n_pkg::PITCH_W'($urandom);
      default: begin
        k = $urandom_range(12, 19);
        return p2n_pkg::PITCH_W'((1 << k) | ($urandom & ((1 << k) - 1)));
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    note_res_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (notes_pending.size() == 0) begin
        $error("result beat with no pending note");
        err_cnt++;
      end else begin
        exp_r = notes_pending.pop_front();
        if (active_o !== exp_r.act) begin
          $error("active: exp %0d got %0d", exp_r.act, active_o);
          err_cnt++;
        end
        if (note_index_o !== exp_r.note) begin
          $error("note_index: exp %0d got %0d", exp_r.note, note_index_o);
          err_cnt++;
        end
        if (octave_index_o !== exp_r.oct) begin
          $error("octave_index: exp %0d got %0d", exp_r.oct, octave_index_o);
          err_cnt++;
        end
        if (cent_offset_o !== exp_r.cent) begin
          $error("cent_offset: exp %0d got %0d", exp_r.cent, cent_offset_o);
          err_cnt++;
        end
        if (in_tune_o !== exp_r.tune) begin
          $error("in_tune: exp %0d got %0d", exp_r.tune, in_tune_o);
          err_cnt++;
        end
        if (flat_mark_o !== exp_r.flat) begin
          $error("flat_mark: exp %0d got %0d", exp_r.flat, flat_mark_o);
          err_cnt++;
        end
        if (sharp_mark_o !== exp_r.sharp) begin
          $error("sharp_mark: exp %0d got %0d", exp_r.sharp, sharp_mark_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("[pitch_to_note_quantizer] ERROR");
      $finish;
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    pitch_row_t rows[$];
    pitch_row_t row;
    logic [p2n_pkg::REF_W-1:0] seg_ref [NUM_SEGS];
    logic [2:0]                seg_mode [NUM_SEGS];
    logic                      seg_en [NUM_SEGS];
    note_res_t                 a_note;

    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    pitch_in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = p2n_pkg::CFG_REF_PITCH;
    cfg_data_i = '0;
    err_cnt = 0;
    cyc_cnt = 0;
    send_idle = 22;
    recv_idle = 49;
    hold_req = 1'b0;
    ref_q = 18'd112640;
    mode_q = 3'd0;
    enable_q = 1'b1;

    a_note = '0;
    a_note.act  = 1'b1;
    a_note.oct  = 3'd4;
    a_note.tune = 1'b1;
    rows.push_back(pitch_row_t'{20'd0, 1'b1, note_res_t'('0)});
    rows.push_back(pitch_row_t'{20'd5119, 1'b1, note_res_t'('0)});
    rows.push_back(pitch_row_t'{20'd112640, 1'b1, a_note});
    begin
      logic [p2n_pkg::PITCH_W-1:0] plain [20] = '{20'd5120, 20'd5121, 20'd1048575,
        20'd1048574, 20'd225280, 20'd56320, 20'd116000, 20'd109000, 20'd119337,
        20'd106318, 20'd113000, 20'd112300, 20'd8192, 20'd524288, 20'd699051,
        20'd65535, 20'd450560, 20'd28160, 20'd14080, 20'd901120};
      foreach (plain[i]) rows.push_back(pitch_row_t'{plain[i], 1'b0, note_res_t'('0)});
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      row = rows[i];
      offer_pitch(row.pitch, row.typed, row.res);
      pause_sender(i == rows.size() - 1);
    end
    drain_results();

    seg_ref  = '{18'd112640, 18'd256, 18'd262143, 18'd0, 18'd110000,
                 18'(  $urandom_range(256, 262143)), 18'($urandom), 18'd112640};
    seg_mode = '{3'd0, 3'd5, 3'd3, 3'd7, 3'd1, 3'd2, 3'd4, 3'd6};
    seg_en   = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

    for (int s = 0; s < NUM_SEGS; s++) begin
      load_tuning(seg_ref[s], seg_mode[s], seg_en[s]);
      if (s < 3) begin
        send_idle = 22;
        recv_idle = 49;
      end else if (s < 6) begin
        send_idle = 49;
        recv_idle = 22;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (s == 0 || s == 6) hold_req = 1'b1;
      for (int k = 0; k < SEG_ITEMS; k++) begin
        offer_pitch(pick_pitch(), 1'b0, note_res_t'('0));
        pause_sender(k == SEG_ITEMS - 1);
      end
      drain_results();
    end

    if (err_cnt == 0) begin
      $display("[pitch_to_note_quantizer] OK");
    end else begin
      $display("[pitch_to_note_quantizer] ERROR");
    end
    $finish;
  end

endmodule
